/* hdl/hsf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared types, constants and helpers for the scaled forward step unit.
// ----------------------------------------------------------------------------
package hsf_pkg;

  typedef logic [16:0] prob_t;      // Q1.16
  typedef logic [33:0] unscaled_t;  // Q2.32
  typedef logic [39:0] sum_t;       // Q8.32
  typedef logic [39:0] scale_t;     // Q24.16
  typedef logic [5:0]  sidx_t;

  localparam prob_t  ONE_Q16   = 17'h10000;
  localparam scale_t SCALE_MAX = 40'hFF_FFFF_FFFF;
  // 2^48 has a single one at this position
  localparam logic [5:0] DIV_MSB = 6'd48;

  function automatic prob_t sat_prob(input prob_t v);
    sat_prob = (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage
`default_nettype wire

/* hdl/hmm_scaled_forward_step_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_unit
// Scaled forward recursion of a haploid hmm, one hidden state per beat.
// ----------------------------------------------------------------------------
// One input beat passes through these steps: read of the previous alpha ram, the inner
// product, the emission product, then the write of the unscaled value and the
// running sum update. A beat flagged last in column then closes the column:
// the serial divider forms the scale, and each stored state is read out in
// turn (ram read, two partial products of the scale multiply, normalize and
// write back); the write back waits while out_stall holds a pending output. Input
// is stalled until the column readout has finished.
module hmm_scaled_forward_step_unit #(
  parameter int MAX_STATES = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire hsf_pkg::prob_t      in_emission,
  input  wire hsf_pkg::prob_t      in_stay_rate,
  input  wire hsf_pkg::prob_t      in_jump_term,
  input  wire hsf_pkg::prob_t      in_prior,
  input  wire logic                in_first_column,
  input  wire logic                in_last_in_column,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hsf_pkg::sidx_t           out_state_index,
  output hsf_pkg::prob_t           out_alpha,
  output hsf_pkg::scale_t          out_scale,
  output logic                     out_last_of_column
);
  import hsf_pkg::*;

  localparam int AW = $clog2(MAX_STATES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INNER = 4'd1;
  localparam logic [3:0] S_PROD  = 4'd2;
  localparam logic [3:0] S_STORE = 4'd3;
  localparam logic [3:0] S_DIVS  = 4'd4;
  localparam logic [3:0] S_DIVW  = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_M0    = 4'd7;
  localparam logic [3:0] S_M1    = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          full_r, full_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  sum_t          sum_r, sum_nxt;

  prob_t         e_r, s_r, j_r, p_r;
  logic          first_r, last_r;
  unscaled_t     inner_r, inner_nxt;
  unscaled_t     u_r, u_nxt;
  unscaled_t     uh_r;
  scale_t        scale_r;
  logic [53:0]   plo_r, phi_r;

  logic          ov_r, ov_nxt;
  sidx_t         o_idx_r;
  prob_t         o_alpha_r;
  scale_t        o_scale_r;
  logic          o_last_r;

  prob_t         prev_rd;
  unscaled_t     uns_rd;
  logic          prev_we, uns_we;
  logic          div_start, div_done;
  scale_t        div_q;

  logic          accept;
  logic          out_free;
  logic          last_idx_hit;
  logic [AW-1:0] last_idx;

  logic [33:0]   sp_prod;
  unscaled_t     emul_a;
  logic [50:0]   emul_p;
  unscaled_t     rmul_a;
  logic [19:0]   rmul_b;
  logic [53:0]   rmul_p;
  logic [73:0]   ptotal;
  logic [41:0]   aq;
  prob_t         alpha_v;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !ov_r || !out_stall;

  // previous alpha store, read at the fill slot, written during readout
  hsf_ram #(.WIDTH(17), .DEPTH(MAX_STATES)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (idx_r),
    .wdata (alpha_v),
    .raddr (cnt_r),
    .rdata (prev_rd)
  );

  // unscaled column store, written at the fill slot, read during readout
  hsf_ram #(.WIDTH(34), .DEPTH(MAX_STATES)) u_uns_ram (
    .clk   (clk),
    .we    (uns_we),
    .waddr (cnt_r),
    .wdata (u_r),
    .raddr (idx_r),
    .rdata (uns_rd)
  );

  hsf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (sum_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // item path arithmetic
  assign sp_prod   = s_r * prev_rd;
  assign inner_nxt = 34'(sp_prod + {1'b0, j_r, 16'h0000});
  assign emul_a    = first_r ? {17'h0, p_r} : inner_r;
  assign emul_p    = e_r * emul_a;
  assign u_nxt     = first_r ? emul_p[33:0] : emul_p[49:16];

  // readout arithmetic
  assign rmul_a = (state_r == S_M0) ? uns_rd : uh_r;
  assign rmul_b = (state_r == S_M0) ? scale_r[19:0] : scale_r[39:20];
  assign rmul_p = rmul_a * rmul_b;
  assign ptotal = {phi_r, 20'h0} + {20'h0, plo_r};
  assign aq     = ptotal[73:32];
  assign alpha_v = (aq > {25'h0, ONE_Q16}) ? ONE_Q16 : aq[16:0];

  assign last_idx     = full_r ? AW'(MAX_STATES - 1) : cnt_r - 1'b1;
  assign last_idx_hit = (idx_r == last_idx);

  assign uns_we    = (state_r == S_STORE) && !full_r;
  assign prev_we   = (state_r == S_FIN) && out_free;
  assign div_start = (state_r == S_DIVS);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    full_nxt  = full_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    ov_nxt    = ov_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_INNER;
        end
      end
      S_INNER: begin
        state_nxt = S_PROD;
      end
      S_PROD: begin
        state_nxt = S_STORE;
      end
      S_STORE: begin
        if (!full_r) begin
          sum_nxt = sum_r + {6'h0, u_r};
          if (cnt_r == AW'(MAX_STATES - 1)) begin
            full_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        idx_nxt   = '0;
        state_nxt = last_r ? S_DIVS : S_IDLE;
      end
      S_DIVS: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_M0;
      end
      S_M0: begin
        state_nxt = S_M1;
      end
      S_M1: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          if (last_idx_hit) begin
            sum_nxt   = '0;
            cnt_nxt   = '0;
            full_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      full_r  <= 1'b0;
      idx_r   <= '0;
      sum_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      full_r  <= full_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_r     <= sat_prob(in_emission);
      s_r     <= sat_prob(in_stay_rate);
      j_r     <= sat_prob(in_jump_term);
      p_r     <= sat_prob(in_prior);
      first_r <= in_first_column;
      last_r  <= in_last_in_column;
    end
    if (state_r == S_INNER) begin
      inner_r <= inner_nxt;
    end
    if (state_r == S_PROD) begin
      u_r <= u_nxt;
    end
    if ((state_r == S_DIVW) && div_done) begin
      scale_r <= div_q;
    end
    if (state_r == S_M0) begin
      uh_r  <= uns_rd;
      plo_r <= rmul_p;
    end
    if (state_r == S_M1) begin
      phi_r <= rmul_p;
    end
    if (prev_we) begin
      o_idx_r   <= 6'(idx_r);
      o_alpha_r <= alpha_v;
      o_scale_r <= scale_r;
      o_last_r  <= last_idx_hit;
    end
  end

  assign out_valid          = ov_r;
  assign out_state_index    = o_idx_r;
  assign out_alpha          = o_alpha_r;
  assign out_scale          = o_scale_r;
  assign out_last_of_column = o_last_r;

endmodule
`default_nettype wire

/* hdl/hsf_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsf_ram
// Simple dual-port synchronous ram, one write and one registered read.
// ----------------------------------------------------------------------------
module hsf_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hdl/hsf_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsf_div
// Restoring divider forming 2^48 / divisor one quotient bit per cycle,
// saturated to the 40-bit scale range.
// ----------------------------------------------------------------------------
module hsf_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire hsf_pkg::sum_t   divisor,
  output logic                 done,
  output hsf_pkg::scale_t      quotient
);
  import hsf_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [39:0] rem_r, rem_nxt;
  logic [48:0] quo_r, quo_nxt;
  logic [40:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r, (pos_r == DIV_MSB)};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    pos_nxt  = pos_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      pos_nxt  = DIV_MSB;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? 40'(rem_sh - {1'b0, divisor}) : rem_sh[39:0];
      quo_nxt = {quo_r[47:0], ge};
      pos_nxt = pos_r - 6'd1;
      if (pos_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    pos_r <= pos_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = ((divisor == '0) || (quo_r[48:40] != '0)) ? SCALE_MAX : quo_r[39:0];

endmodule
`default_nettype wire

/* tb/sv/hmm_scaled_forward_step_unit_test.sv */
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_unit_test
// Self-checking bench for the scaled forward step unit. Hidden states are fed
// column by column. A local model of the recursion predicts every normalised
// alpha, its column scale and the end-of-column flag. Each output beat is then
// checked against the oldest prediction. Directed columns cover the extremes
// and the corner cases: zero and tiny sums, and a column that overflows its
// slots while the output is held off. Random chains and noise follow. Both
// sides idle at random.
// ----------------------------------------------------------------------------
module hmm_scaled_forward_step_unit_test;
  import hsf_pkg::*;

  localparam int STATE_SLOTS = 32;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    prob_t emission;
    prob_t stay_rate;
    prob_t jump_term;
    prob_t prior;
    logic  first_column;
    logic  last_in_column;
  } state_beat_t;

  typedef struct {
    sidx_t  state_index;
    prob_t  alpha;
    scale_t scale;
    logic   last_of_column;
  } alpha_beat_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  prob_t   in_emission = '0;
  prob_t   in_stay_rate = '0;
  prob_t   in_jump_term = '0;
  prob_t   in_prior = '0;
  logic    in_first_column = 1'b0;
  logic    in_last_in_column = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sidx_t   out_state_index;
  prob_t   out_alpha;
  scale_t  out_scale;
  logic    out_last_of_column;

  // local copy of the recursion state
  prob_t     prev_alpha [STATE_SLOTS];
  unscaled_t unscaled [STATE_SLOTS];
  bit        alpha_known [STATE_SLOTS];
  sum_t      col_sum = '0;
  int        col_slot = 0;
  bit        col_full = 1'b0;

  alpha_beat_t expected_alphas[$];

  int fail_count = 0;
  int beats_sent = 0;
  int alpha_beats = 0;
  int columns_closed = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;
  int stall_pct = 0;
  int hold_ask = 0;
  int hold_done = 0;
  int hold_left = 0;

  hmm_scaled_forward_step_unit #(
    .MAX_STATES(STATE_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_emission(in_emission),
    .in_stay_rate(in_stay_rate),
    .in_jump_term(in_jump_term),
    .in_prior(in_prior),
    .in_first_column(in_first_column),
    .in_last_in_column(in_last_in_column),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_state_index(out_state_index),
    .out_alpha(out_alpha),
    .out_scale(out_scale),
    .out_last_of_column(out_last_of_column)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] clip_prob(input prob_t v);
    return (v > ONE_Q16) ? 64'(ONE_Q16) : 64'(v);
  endfunction

  function automatic state_beat_t make_state(input prob_t em, input prob_t st,
                                             input prob_t jp, input prob_t pr,
                                             input logic first, input logic last);
    state_beat_t s;
    s.emission = em;
    s.stay_rate = st;
    s.jump_term = jp;
    s.prior = pr;
    s.first_column = first;
    s.last_in_column = last;
    return s;
  endfunction

  function automatic prob_t rand_prob(input bit noisy);
    return noisy ? prob_t'($urandom_range(0, 17'h1FFFF)) : prob_t'($urandom_range(0, 65536));
  endfunction

  // one accepted state: store its unscaled value, and on a column end
  // queue the normalised alphas
  function automatic void forward_predict(input state_beat_t s);
    logic [63:0] em, st, jp, pr, inner, u, quot, a;
    logic [79:0] prod;
    alpha_beat_t r;
    int n, i;
    em = clip_prob(s.emission);
    st = clip_prob(s.stay_rate);
    jp = clip_prob(s.jump_term);
    pr = clip_prob(s.prior);
    if (!col_full) begin
      if (s.first_column) begin
        u = pr * em;
      end else begin
        inner = st * 64'(prev_alpha[col_slot]) + (jp << 16);
        u = (em * inner) >> 16;
      end
      unscaled[col_slot] = u[33:0];
      col_sum = col_sum + sum_t'(u[33:0]);
      if (col_slot == STATE_SLOTS - 1) col_full = 1'b1;
      else col_slot++;
    end
    if (!s.last_in_column) return;
    n = col_full ? STATE_SLOTS : col_slot;
    if (col_sum == '0) begin
      quot = 64'(SCALE_MAX);
    end else begin
      quot = (64'd1 << 48) / 64'(col_sum);
      if (quot > 64'(SCALE_MAX)) quot = 64'(SCALE_MAX);
    end
    for (i = 0; i < n; i++) begin
      prod = 80'(unscaled[i]) * 80'(quot);
      a = 64'(prod >> 32);
      if (a > 64'(ONE_Q16)) a = 64'(ONE_Q16);
      prev_alpha[i] = a[16:0];
      alpha_known[i] = 1'b1;
      r.state_index = sidx_t'(i);
      r.alpha = a[16:0];
      r.scale = quot[39:0];
      r.last_of_column = (i == n - 1);
      expected_alphas = {expected_alphas, r};
    end
    col_sum = '0;
    col_slot = 0;
    col_full = 1'b0;
  endfunction

  task automatic send_state(input state_beat_t s);
    // a later-column state may only read a slot that a column end has written
    if (!s.first_column && !col_full && !alpha_known[col_slot]) s.first_column = 1'b1;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_emission <= s.emission;
    in_stay_rate <= s.stay_rate;
    in_jump_term <= s.jump_term;
    in_prior <= s.prior;
    in_first_column <= s.first_column;
    in_last_in_column <= s.last_in_column;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    forward_predict(s);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_alphas.size() != 0) @(posedge clk);
  endtask

  // receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_ask != hold_done) begin
      hold_done = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : alpha_check
    alpha_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_alphas.size() == 0) begin
        $error("unexpected alpha beat, state_index %0d alpha %0d", out_state_index, out_alpha);
        fail_count++;
      end else begin
        want = expected_alphas.pop_front();
        if (out_state_index !== want.state_index) begin
          $error("state_index: expected %0d, got %0d", want.state_index, out_state_index);
          fail_count++;
        end
        if (out_alpha !== want.alpha) begin
          $error("alpha: expected %0d, got %0d", want.alpha, out_alpha);
          fail_count++;
        end
        if (out_scale !== want.scale) begin
          $error("scale: expected %0d, got %0d", want.scale, out_scale);
          fail_count++;
        end
        if (out_last_of_column !== want.last_of_column) begin
          $error("last_of_column: expected %0b, got %0b", want.last_of_column,
                 out_last_of_column);
          fail_count++;
        end
      end
      alpha_beats++;
      if (out_last_of_column === 1'b1) columns_closed++;
    end
  end

  // no idling on either side here
  task automatic test_first_column();
    gaps_on = 1'b0;
    stall_pct = 0;
    send_state(make_state(17'h10000, 17'h1FFFF, 17'h0AAAA, 17'h10000, 1'b1, 1'b0));
    send_state(make_state(17'h1FFFF, 17'h0, 17'h15555, 17'h1FFFF, 1'b1, 1'b0));
    send_state(make_state(17'h0, 17'h0AAAA, 17'h1FFFF, 17'h0FFFF, 1'b1, 1'b0));
    send_state(make_state(17'h00001, 17'h15555, 17'h0, 17'h15555, 1'b1, 1'b1));
    drain_results();
  endtask

  task automatic test_later_columns();
    gaps_on = 1'b1;
    stall_pct = 30;
    send_state(make_state(17'h10000, 17'h1FFFF, 17'h0, 17'h1FFFF, 1'b0, 1'b0));
    send_state(make_state(17'h1FFFF, 17'h0, 17'h1FFFF, 17'h0, 1'b0, 1'b0));
    send_state(make_state(17'h0AAAA, 17'h15555, 17'h0AAAA, 17'h15555, 1'b0, 1'b0));
    send_state(make_state(17'h05555, 17'h10000, 17'h10000, 17'h0AAAA, 1'b0, 1'b1));
    drain_results();
  endtask

  // all unscaled values zero: scale saturates, alphas are zero
  task automatic test_zero_sum();
    stall_pct = 50;
    send_state(make_state(17'h10000, 17'h10000, 17'h10000, 17'h0, 1'b1, 1'b0));
    send_state(make_state(17'h0, 17'h10000, 17'h10000, 17'h10000, 1'b1, 1'b1));
    drain_results();
  endtask

  // tiny sums push the quotient past the scale range
  task automatic test_tiny_sum();
    stall_pct = 20;
    send_state(make_state(17'h00001, 17'h0, 17'h0, 17'h00001, 1'b1, 1'b0));
    send_state(make_state(17'h10000, 17'h0, 17'h0, 17'h0, 1'b1, 1'b1));
    send_state(make_state(17'h00001, 17'h0, 17'h0, 17'h00003, 1'b1, 1'b1));
    drain_results();
  endtask

  // more states than slots while the output is held off, then a follow-up
  // column offered against the stalled input
  task automatic test_overflow_under_hold();
    int i;
    gaps_on = 1'b1;
    stall_pct = 0;
    hold_ask++;
    for (i = 0; i < STATE_SLOTS + 2; i++) begin
      send_state(make_state(rand_prob(0), rand_prob(0), rand_prob(0), rand_prob(0), 1'b1,
                            i == STATE_SLOTS + 1));
    end
    for (i = 0; i < 3; i++) begin
      send_state(make_state(rand_prob(0), 17'h0C000, rand_prob(0), rand_prob(0), 1'b0,
                            i == 2));
    end
    drain_results();
  endtask

  task automatic test_random_columns();
    int start, k, ncols, len, c, i;
    prob_t stay;
    bit noisy;
    start = beats_sent;
    while (beats_sent - start < 64) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        7, 8: begin
          len = $urandom_range(1, 10);
          for (i = 0; i < len; i++) begin
            send_state(make_state(rand_prob(1), rand_prob(1), rand_prob(1), rand_prob(1),
                                  1'($urandom_range(0, 1)), i == len - 1));
          end
        end
        9: begin
          len = ($urandom_range(0, 7) == 0) ? 36 : $urandom_range(1, 12);
          for (i = 0; i < len; i++) begin
            send_state(make_state(rand_prob(1), rand_prob(0), rand_prob(0), rand_prob(1),
                                  1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0));
          end
        end
        default: begin
          k = ($urandom_range(0, 11) == 0) ? STATE_SLOTS : $urandom_range(2, 8);
          ncols = (k == STATE_SLOTS) ? 2 : $urandom_range(2, 5);
          for (c = 0; c < ncols; c++) begin
            stall_pct = $urandom_range(0, 3) * 25;
            stay = rand_prob(0);
            for (i = 0; i < k; i++) begin
              noisy = ($urandom_range(0, 15) == 0);
              send_state(make_state(rand_prob(noisy), stay, rand_prob(noisy),
                                    rand_prob(noisy), c == 0, i == k - 1));
            end
          end
        end
      endcase
      if ($urandom_range(0, 5) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_column();
    test_later_columns();
    test_zero_sum();
    test_tiny_sum();
    test_overflow_under_hold();
    test_random_columns();
    drain_results();
    repeat (300) @(posedge clk);
    if (expected_alphas.size() != 0) begin
      $error("%0d alpha beats never arrived", expected_alphas.size());
      fail_count++;
    end
    $display("sent %0d state beats; checked %0d alpha beats over %0d closed columns",
             beats_sent, alpha_beats, columns_closed);
    $display("covered zero and tiny sums, slot overflow under a long output hold-off");
    if (fail_count == 0) begin
      $display("hmm_scaled_forward_step_unit_test passed");
    end else begin
      $display("hmm_scaled_forward_step_unit_test failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("hmm_scaled_forward_step_unit_test failed");
    $finish;
  end

endmodule
